// ===== rtl/pidl_pkg.sv =====
// ----------------------------------------------------------------------------
// pidl_pkg
// Shared constants, codes and types for the positional insert/delete list.
// ----------------------------------------------------------------------------
`default_nettype none

package pidl_pkg;

  // Field widths fixed by the interface.
  localparam int WORD_W     = 32;
  localparam int POS_W      = 4;
  localparam int OP_W       = 3;
  localparam int STATUS_W   = 2;
  localparam int COUNT_OUT_W = 5;

  // Default number of slots in the cell row.
  localparam int DEFAULT_ENTRIES = 16;

  // Opcodes.
  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_POS   = 3'd1;
  localparam logic [OP_W-1:0] OP_REM_BACK  = 3'd2;
  localparam logic [OP_W-1:0] OP_REM_POS   = 3'd3;
  localparam logic [OP_W-1:0] OP_REM_FRONT = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  // What every cell of the row does on the current edge.
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_HOLD = 2'd0;
  localparam mode_t MODE_INS  = 2'd1;
  localparam mode_t MODE_REM  = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/positional_insert_delete_list_unit.sv =====
// ----------------------------------------------------------------------------
// positional_insert_delete_list_unit
// Ordered list of signed 32-bit words kept in a row of shifting cells.
// ----------------------------------------------------------------------------
// The unit takes one item per clock cycle and returns exactly one result for
// each item, in the cycle after the item's transfer. All ENTRIES slots sit in a
// row of cells that update together on the edge at which an item is taken:
// each cell holds, loads the new word, copies its left neighbor (insert) or
// copies its right neighbor (remove), so an insert or remove of any length
// finishes on that edge and the cell row is what sets the rate of one
// item per cycle. The result sits in an output register; the input side
// stays ready while that register is empty or is being drained in the same
// cycle, so a result left waiting holds off the next transfer until the
// receiver takes it.
// Status codes are done, position out of range, list empty and list full.
// Positional insert and remove accept positions 1 to count-1 only. A rejected
// item changes neither the list nor the count. The readback field returns
// the entry at the item's position after the item, or zero when that
// position is not below the new count.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_insert_delete_list_unit #(
  parameter int ENTRIES = pidl_pkg::DEFAULT_ENTRIES
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire        [pidl_pkg::OP_W-1:0]      opcode,
  input  wire        [pidl_pkg::POS_W-1:0]     position,
  input  wire signed [pidl_pkg::WORD_W-1:0]    word_in,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic       [pidl_pkg::STATUS_W-1:0]  status,
  output logic       [pidl_pkg::COUNT_OUT_W-1:0] entry_count,
  output logic signed [pidl_pkg::WORD_W-1:0]   entry_at_position
);
  import pidl_pkg::*;

  // Count width holds ENTRIES itself; compares against the 4-bit position
  // are done at the wider of the two widths.
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  // Only the first sixteen slots can ever be addressed for readback.
  localparam int RB_W  = ($clog2(ENTRIES) < POS_W) ? $clog2(ENTRIES) : POS_W;
  localparam int RB_N  = 2 ** RB_W;

  logic                    in_xfer;
  mode_t                   mode;
  logic [CNT_W-1:0]        pos;
  logic [CNT_W-1:0]        last;
  logic [CNT_W-1:0]        fill;
  logic [CNT_W-1:0]        fill_next;
  logic [STATUS_W-1:0]     status_c;
  logic signed [WORD_W-1:0] slot      [ENTRIES];
  logic signed [WORD_W-1:0] slot_next [ENTRIES];
  logic signed [WORD_W-1:0] rb        [RB_N];
  logic signed [WORD_W-1:0] readback;
  logic                    out_valid_next;

  // A new item may enter whenever the output register is free now or is
  // handed off on this same edge.
  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  pidl_ctl #(
    .ENTRIES (ENTRIES),
    .CNT_W   (CNT_W)
  ) u_ctl (
    .clk       (clk),
    .rst       (rst),
    .go        (in_xfer),
    .opcode    (opcode),
    .position  (position),
    .mode      (mode),
    .pos       (pos),
    .last      (last),
    .fill      (fill),
    .fill_next (fill_next),
    .status    (status_c)
  );

  // The cell row. The end cells see zero past the ends of the row; those
  // inputs are never selected by a legal shift.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic signed [WORD_W-1:0] left;
    logic signed [WORD_W-1:0] right;

    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = slot[i-1];
    end

    if (i == ENTRIES - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = slot[i+1];
    end

    pidl_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .mode      (mode),
      .pos       (pos),
      .last      (last),
      .fill      (fill),
      .word_in   (word_in),
      .left      (left),
      .right     (right),
      .slot      (slot[i]),
      .slot_next (slot_next[i])
    );
  end

  // Readback taps the cells' next values so the result shows the list as it
  // stands after the item. Taps past the end of a short row read as zero;
  // they are never selected because the position is then beyond the count.
  for (genvar k = 0; k < RB_N; k++) begin : g_rb
    if (k < ENTRIES) begin : g_tap
      assign rb[k] = slot_next[k];
    end else begin : g_pad
      assign rb[k] = '0;
    end
  end

  assign readback = (CMP_W'(position) < CMP_W'(fill_next)) ? rb[position[RB_W-1:0]] : '0;

  // Output register: valid is control, the payload needs no reset.
  assign out_valid_next = in_xfer || (out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      status            <= status_c;
      entry_count       <= COUNT_OUT_W'(fill_next);
      entry_at_position <= readback;
    end
  end

  // The count never leaves the range of the row.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(ENTRIES))
    else $error("fill count exceeds the number of slots");

  // A rejected item leaves the count where it was.
  a_reject_holds: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (status_c != ST_DONE) |=> fill == $past(fill))
    else $error("rejected item changed the fill count");

  // Full is reported only when every slot is taken.
  a_full_only_full: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (status_c == ST_FULL) |-> fill == CNT_W'(ENTRIES))
    else $error("full status with free slots");

  // Every transfer in produces a result in the next cycle, and the reported
  // count matches the stored count.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> out_valid && (entry_count == COUNT_OUT_W'(fill)))
    else $error("result missing or count mismatch after a transfer");

endmodule

`default_nettype wire

// ===== rtl/pidl_cell.sv =====
// ----------------------------------------------------------------------------
// pidl_cell
// One slot of the list row: holds, loads the new word, takes its left
// neighbor (insert shift) or takes its right neighbor (remove shift).
// ----------------------------------------------------------------------------
`default_nettype none

module pidl_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire pidl_pkg::mode_t              mode,
  input  wire        [CNT_W-1:0]            pos,
  input  wire        [CNT_W-1:0]            last,
  input  wire        [CNT_W-1:0]            fill,
  input  wire signed [pidl_pkg::WORD_W-1:0] word_in,
  input  wire signed [pidl_pkg::WORD_W-1:0] left,
  input  wire signed [pidl_pkg::WORD_W-1:0] right,
  output logic signed [pidl_pkg::WORD_W-1:0] slot,
  output logic signed [pidl_pkg::WORD_W-1:0] slot_next
);
  import pidl_pkg::*;

  localparam logic [CNT_W-1:0] ME = CNT_W'(IDX);

  always_comb begin
    slot_next = slot;
    case (mode)
      MODE_INS: begin
        if (ME == pos) begin
          slot_next = word_in;
        end else if ((ME > pos) && (ME <= fill)) begin
          slot_next = left;
        end
      end
      MODE_REM: begin
        if ((ME >= pos) && (ME < last)) begin
          slot_next = right;
        end else if (ME == last) begin
          slot_next = '0;
        end
      end
      default: begin
        slot_next = slot;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else begin
      slot <= slot_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pidl_ctl.sv =====
// ----------------------------------------------------------------------------
// pidl_ctl
// Checks each item against the fill count, sets the status, keeps the
// count and broadcasts the shift mode and bounds to the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

module pidl_ctl #(
  parameter int ENTRIES = pidl_pkg::DEFAULT_ENTRIES,
  parameter int CNT_W   = $clog2(ENTRIES + 1)
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              go,
  input  wire [pidl_pkg::OP_W-1:0]         opcode,
  input  wire [pidl_pkg::POS_W-1:0]        position,
  output pidl_pkg::mode_t                  mode,
  output logic [CNT_W-1:0]                 pos,
  output logic [CNT_W-1:0]                 last,
  output logic [CNT_W-1:0]                 fill,
  output logic [CNT_W-1:0]                 fill_next,
  output logic [pidl_pkg::STATUS_W-1:0]    status
);
  import pidl_pkg::*;

  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

  logic            empty;
  logic            full;
  logic            pos_ok;
  logic [CNT_W-1:0] pos_req;
  mode_t           mode_req;
  logic [CNT_W-1:0] fill_req;

  assign empty   = (fill == '0);
  assign full    = (fill == FULL_CNT);
  assign pos_ok  = (position != '0) && (CMP_W'(position) < CMP_W'(fill));
  assign last    = fill - CNT_W'(1);

  always_comb begin
    status   = ST_DONE;
    mode_req = MODE_HOLD;
    pos_req  = '0;
    fill_req = fill;
    case (opcode)
      OP_INS_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          mode_req = MODE_INS;
          fill_req = fill + CNT_W'(1);
        end
      end
      OP_INS_POS: begin
        if (!pos_ok) begin
          status = ST_RANGE;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          mode_req = MODE_INS;
          pos_req  = CNT_W'(position);
          fill_req = fill + CNT_W'(1);
        end
      end
      OP_REM_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          mode_req = MODE_REM;
          pos_req  = last;
          fill_req = last;
        end
      end
      OP_REM_POS: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (!pos_ok) begin
          status = ST_RANGE;
        end else begin
          mode_req = MODE_REM;
          pos_req  = CNT_W'(position);
          fill_req = last;
        end
      end
      OP_REM_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          mode_req = MODE_REM;
          fill_req = last;
        end
      end
      default: begin
        status = ST_DONE;
      end
    endcase
  end

  assign mode      = go ? mode_req : MODE_HOLD;
  assign pos       = pos_req;
  assign fill_next = go ? fill_req : fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the positional insert/delete list unit.
// ----------------------------------------------------------------------------
// Items are sent over the input valid/ready channel. Each transfer updates a
// shadow copy of the list kept in the bench, and that copy predicts the one
// result the item should produce. A checker process compares every result
// transfer, field by field, with the oldest prediction. Directed tests cover
// the empty list, a full store and the edges of the positional range. Random
// tests then push the list back and forth between empty and full, with random
// idling on both channels, a long receiver hold-off and a no-idle stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pidl_pkg::*;

  localparam int ENTRIES     = DEFAULT_ENTRIES;
  localparam int IDLE_PCT    = 34;
  localparam int LATENCY     = 1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SPARE_OPS   = (1 << OP_W) - 1 - int'(OP_REM_FRONT);
  localparam int POS_MAX     = (1 << POS_W) - 1;

  // One predicted result: status, count after the item and the readback.
  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [COUNT_OUT_W-1:0] count;
    logic [WORD_W-1:0]      entry;
  } list_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [OP_W-1:0]         opcode = OP_INS_FRONT;
  logic [POS_W-1:0]        position = '0;
  logic signed [WORD_W-1:0] word_in = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [STATUS_W-1:0]     status;
  logic [COUNT_OUT_W-1:0]  entry_count;
  logic signed [WORD_W-1:0] entry_at_position;

  positional_insert_delete_list_unit #(.ENTRIES(ENTRIES)) DUT (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .opcode            (opcode),
    .position          (position),
    .word_in           (word_in),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .entry_count       (entry_count),
    .entry_at_position (entry_at_position)
  );

  always #1 clk = ~clk;

  // Shadow copy of the list, advanced once per accepted item.
  logic [WORD_W-1:0] shadow_slots [ENTRIES];
  int unsigned       shadow_fill;
  list_result_t      pending_results [$];

  // Controls shared by the tests and the channel processes.
  bit feed_steady;      // sender offers items back to back
  bit drain_steady;     // receiver keeps ready high
  int stall_hold;       // receiver hold-off still to run, in cycles

  int mismatches;
  int items_sent;
  int results_seen;
  int cycle_count;
  int full_hits;
  int empty_hits;
  int range_hits;

  initial begin
    for (int i = 0; i < ENTRIES; i++) shadow_slots[i] = '0;
    shadow_fill = 0;
  end

  // Opens a gap at position p and stores w there.
  function automatic void shadow_insert(input int unsigned p, input logic [WORD_W-1:0] w);
    for (int unsigned i = shadow_fill; i > p; i--) shadow_slots[i] = shadow_slots[i-1];
    shadow_slots[p] = w;
    shadow_fill++;
  endfunction

  // Closes the gap at position p; the slot freed at the back reads as zero.
  function automatic void shadow_remove(input int unsigned p);
    for (int unsigned i = p; i + 1 < shadow_fill; i++) shadow_slots[i] = shadow_slots[i+1];
    shadow_slots[shadow_fill-1] = '0;
    shadow_fill--;
  endfunction

  // Applies one item to the shadow list and returns the result it should give.
  function automatic list_result_t apply_list_op(input logic [OP_W-1:0] op,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic [WORD_W-1:0] word);
    list_result_t r;
    bit           pos_ok;
    r.status = ST_DONE;
    pos_ok = (pos >= 1) && (pos < shadow_fill);
    case (op)
      OP_INS_FRONT: begin
        if (shadow_fill >= ENTRIES) r.status = ST_FULL;
        else shadow_insert(0, word);
      end
      OP_INS_POS: begin
        // The range test comes before the full test.
        if (!pos_ok) r.status = ST_RANGE;
        else if (shadow_fill >= ENTRIES) r.status = ST_FULL;
        else shadow_insert(pos, word);
      end
      OP_REM_BACK: begin
        if (shadow_fill == 0) r.status = ST_EMPTY;
        else shadow_remove(shadow_fill - 1);
      end
      OP_REM_POS: begin
        // An empty list is reported before a bad position.
        if (shadow_fill == 0) r.status = ST_EMPTY;
        else if (!pos_ok) r.status = ST_RANGE;
        else shadow_remove(pos);
      end
      OP_REM_FRONT: begin
        if (shadow_fill == 0) r.status = ST_EMPTY;
        else shadow_remove(0);
      end
      default: begin
        // Spare opcodes only read back.
      end
    endcase
    r.count = COUNT_OUT_W'(shadow_fill);
    r.entry = (pos < shadow_fill) ? shadow_slots[pos] : '0;
    return r;
  endfunction

  // Offers one item, waits for its transfer and records the prediction.
  // Valid is only lowered when a gap is taken, so it is never lowered and
  // raised again at the same edge.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic [WORD_W-1:0] word);
    list_result_t r;
    int           gap;
    gap = 0;
    while (!feed_steady && $urandom_range(99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    position <= pos;
    word_in  <= word;
    do @(posedge clk); while (!in_ready);
    r = apply_list_op(op, pos, word);
    pending_results.push_back(r);
    items_sent++;
    if (r.status == ST_FULL) full_hits++;
    if (r.status == ST_EMPTY) empty_hits++;
    if (r.status == ST_RANGE) range_hits++;
  endtask

  // Sender pause: drop valid and wait until every prediction has been met.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Receiver: checks each result transfer and decides ready for the next edge.
  always @(posedge clk) begin
    list_result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with no prediction waiting: status %0d count %0d entry %0d",
                   $time, status, entry_count, entry_at_position);
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status) begin
            mismatches++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          end
          if (entry_count !== want.count) begin
            mismatches++;
            $display("%0t: entry_count expected %0d actual %0d",
                     $time, want.count, entry_count);
          end
          if (entry_at_position !== want.entry) begin
            mismatches++;
            $display("%0t: entry_at_position expected %0d actual %0d",
                     $time, $signed(want.entry), entry_at_position);
          end
        end
      end
      if (stall_hold > 0) begin
        stall_hold = stall_hold - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= drain_steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Every remove on an empty list, a bad positional insert and a spare opcode.
  task automatic test_empty_list();
    send_item(OP_REM_BACK, 4'd0, '0);
    send_item(OP_REM_POS, 4'd0, '0);
    send_item(OP_REM_FRONT, 4'd3, '1);
    send_item(OP_INS_POS, 4'd1, 32'h1234_5678);
    send_item(OP_REM_FRONT + OP_W'(SPARE_OPS), POS_W'(POS_MAX), '1);
    wait_for_results();
  endtask

  // Fill the store with extreme words, then try both inserts on a full list.
  task automatic test_full_store();
    logic [WORD_W-1:0] pattern;
    for (int i = 0; i < ENTRIES; i++) begin
      case (i % 6)
        0: pattern = 32'h8000_0000;
        1: pattern = 32'h7FFF_FFFF;
        2: pattern = 32'hFFFF_FFFF;
        3: pattern = 32'h0000_0000;
        4: pattern = 32'hAAAA_AAAA;
        default: pattern = 32'h5555_5555;
      endcase
      send_item(OP_INS_FRONT, POS_W'(i), pattern);
    end
    send_item(OP_INS_FRONT, 4'd0, 32'h0BAD_F00D);
    send_item(OP_INS_POS, POS_W'(POS_MAX), 32'h0BAD_F00D);
    send_item(OP_INS_POS, 4'd0, 32'h0BAD_F00D);
    wait_for_results();
  endtask

  // Positions at both ends of the accepted range, and just outside it.
  task automatic test_position_edges();
    send_item(OP_REM_POS, POS_W'(POS_MAX), '0);     // last entry, accepted
    send_item(OP_REM_POS, 4'd0, '0);                // front, never accepted
    send_item(OP_REM_POS, POS_W'(POS_MAX), '0);     // now equal to the count
    send_item(OP_INS_POS, POS_W'(POS_MAX - 1), 32'hC0DE_0001);
    send_item(OP_REM_BACK, 4'd2, '0);
    send_item(OP_REM_FRONT, 4'd0, '0);
    wait_for_results();
  endtask

  function automatic logic [OP_W-1:0] pick_op(input bit growing);
    int roll;
    roll = $urandom_range(99);
    if (roll < 4) return OP_REM_FRONT + OP_W'($urandom_range(1, SPARE_OPS));
    if (roll < (growing ? 70 : 34)) return $urandom_range(1) ? OP_INS_FRONT : OP_INS_POS;
    case ($urandom_range(2))
      0: return OP_REM_BACK;
      1: return OP_REM_POS;
      default: return OP_REM_FRONT;
    endcase
  endfunction

  // Most positions fall inside or just past the list; some are anywhere.
  function automatic logic [POS_W-1:0] pick_position();
    int unsigned top;
    top = (shadow_fill < POS_MAX) ? shadow_fill : POS_MAX;
    if ($urandom_range(99) < 80) return POS_W'($urandom_range(top, 0));
    return POS_W'($urandom_range(POS_MAX, 0));
  endfunction

  // Random items; the bias toward inserts or removes flips now and then so
  // the list keeps travelling between empty and full.
  task automatic test_random_mix(input int count);
    bit growing;
    growing = 1'b1;
    for (int i = 0; i < count; i++) begin
      if (shadow_fill >= ENTRIES && $urandom_range(3) == 0) growing = 1'b0;
      if (shadow_fill == 0 && $urandom_range(3) == 0) growing = 1'b1;
      if ($urandom_range(49) == 0) growing = !growing;
      send_item(pick_op(growing), pick_position(), $urandom());
    end
  endtask

  // Receiver holds off for a long stretch while items keep coming.
  task automatic test_backpressure();
    feed_steady = 1'b1;
    stall_hold  = 40;
    for (int i = 0; i < 12; i++) send_item(pick_op(i < 8), pick_position(), $urandom());
    feed_steady = 1'b0;
    wait_for_results();
  endtask

  // Both sides run without idling for a while.
  task automatic test_streaming();
    feed_steady  = 1'b1;
    drain_steady = 1'b1;
    test_random_mix(100);
    feed_steady  = 1'b0;
    drain_steady = 1'b0;
    wait_for_results();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_list();
    test_full_store();
    test_position_edges();
    test_backpressure();
    test_random_mix(200);
    wait_for_results();
    test_streaming();
    test_random_mix(250);

    wait_for_results();
    repeat (LATENCY + 3) @(posedge clk);

    $display("Covered %0d items and %0d results, with %0d full, %0d empty and %0d range",
             items_sent, results_seen, full_hits, empty_hits, range_hits);
    $display("rejections, under random idling, a long receiver stall and a no-idle stretch.");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
